/* hw/rtl/dcf_pkg.sv */
// shared types, constants and decode helpers for the dcf77 frame receiver
package dcf_pkg;

    localparam int unsigned THR_W = 12;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned POS_W = 6;
    localparam int unsigned Q_DEPTH = 2;

    // threshold register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_MIN = 3'd0,
        REG_ZERO_MAX = 3'd1,
        REG_ONE_MIN  = 3'd2,
        REG_ONE_MAX  = 3'd3,
        REG_GAP_MIN  = 3'd4,
        REG_GAP_MAX  = 3'd5
    } cfg_reg_t;

    // threshold reset values
    localparam logic [THR_W-1:0] ZERO_MIN_RST = 12'd40;
    localparam logic [THR_W-1:0] ZERO_MAX_RST = 12'd130;
    localparam logic [THR_W-1:0] ONE_MIN_RST  = 12'd140;
    localparam logic [THR_W-1:0] ONE_MAX_RST  = 12'd250;
    localparam logic [THR_W-1:0] GAP_MIN_RST  = 12'd1600;
    localparam logic [THR_W-1:0] GAP_MAX_RST  = 12'd2100;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_START_BIT  = 3'd1,
        ST_TIME_BIT   = 3'd2,
        ST_MIN_PARITY = 3'd3,
        ST_HR_PARITY  = 3'd4,
        ST_DATE_PAR   = 3'd5,
        ST_BAD_FRAME  = 3'd6
    } status_t;

    localparam logic [5:0] PM_HOUR = 6'd12;

    // queue occupancy seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // bcd with unclamped low digit: low nibble plus 10, 20, 40, 80
    function automatic logic [7:0] bcd8(input logic [7:0] v);
        logic [7:0] acc;
        acc = {4'd0, v[3:0]};
        acc = acc + (v[4] ? 8'd10 : 8'd0);
        acc = acc + (v[5] ? 8'd20 : 8'd0);
        acc = acc + (v[6] ? 8'd40 : 8'd0);
        acc = acc + (v[7] ? 8'd80 : 8'd0);
        return acc;
    endfunction

endpackage

/* hw/rtl/dcf77_frame_receiver.sv */
// top level of the dcf77 minute frame receiver
//
// channel   dir  handshake              word
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data (threshold write)
// in        in   in_valid/in_ready      pulse_width, period_length (one pulse)
// out       out  out_valid/out_ready    status and decoded time (one per minute)
//
// one pulse is taken per cycle while in_ready is high; the front end
// classifies it and updates the frame in that same cycle, so a new pulse can
// follow immediately; a minute mark pushes the closed frame into a two-deep
// queue; the decoder pops it and registers the result in the output register
// in_ready drops only while the queue is full, i.e. when the output side has
// stalled long enough to back up two frames; cfg_ready is always high
// reset clears the frame, marks it bad and loads the default thresholds
module dcf77_frame_receiver #(
    parameter int unsigned FRAME_BITS = 59
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // pulse words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] pulse_width,
    input  logic [11:0] period_length,
    // decoded minute words
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [6:0]  minutes,
    output logic [5:0]  hours,
    output logic        is_pm,
    output logic [5:0]  day,
    output logic [2:0]  weekday,
    output logic [4:0]  month,
    output logic [7:0]  year
);

    // closed frame plus a bad flag in bit 0 (unknown pulse or wrong length)
    logic                  push;
    logic [FRAME_BITS:0]   push_data;
    logic                  pop;
    logic [FRAME_BITS:0]   head;
    dcf_pkg::q_stat_t      q_stat;

    // classification and bit collection
    dcf_front #(
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pulse_width   (pulse_width),
        .period_length (period_length),
        .q_stat        (q_stat),
        .push          (push),
        .push_data     (push_data)
    );

    // decouples the pulse side from a stalled result consumer
    dcf_queue #(
        .WIDTH (FRAME_BITS + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // start and time bits, parity checks and bcd decode
    dcf_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .minutes   (minutes),
        .hours     (hours),
        .is_pm     (is_pm),
        .day       (day),
        .weekday   (weekday),
        .month     (month),
        .year      (year)
    );

endmodule

/* hw/rtl/dcf_front.sv */
// front end: threshold registers, pulse classification and frame collection
module dcf_front #(
    parameter int unsigned FRAME_BITS = 59
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dcf_pkg::THR_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [dcf_pkg::THR_W-1:0]  pulse_width,
    input  logic [dcf_pkg::THR_W-1:0]  period_length,
    input  dcf_pkg::q_stat_t           q_stat,
    output logic                       push,
    output logic [FRAME_BITS:0]        push_data
);

    localparam logic [dcf_pkg::POS_W-1:0] POS_END = dcf_pkg::POS_W'(FRAME_BITS);
    localparam logic [dcf_pkg::POS_W-1:0] POS_SAT = {dcf_pkg::POS_W{1'b1}};

    logic [dcf_pkg::THR_W-1:0] zero_min_reg, zero_max_reg;
    logic [dcf_pkg::THR_W-1:0] one_min_reg, one_max_reg;
    logic [dcf_pkg::THR_W-1:0] gap_min_reg, gap_max_reg;

    logic [FRAME_BITS-1:0]     frame_reg, frame_next;
    logic [dcf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      bad_reg, bad_next;

    logic accept, is_zero, is_one, is_mark;
    logic [FRAME_BITS-1:0] bit_mask;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_stat.full;
    assign accept    = in_valid && in_ready;

    assign is_zero = (pulse_width > zero_min_reg) && (pulse_width < zero_max_reg);
    assign is_one  = !is_zero && (pulse_width > one_min_reg) && (pulse_width < one_max_reg);
    assign is_mark = is_zero && (period_length > gap_min_reg) && (period_length < gap_max_reg);

    assign bit_mask  = {{(FRAME_BITS-1){1'b0}}, 1'b1} << pos_reg;
    assign push      = accept && is_mark;
    assign push_data = {frame_reg, bad_reg || (pos_reg != POS_END)};

    always_comb
    begin
        frame_next = frame_reg;
        pos_next   = pos_reg;
        bad_next   = bad_reg;
        if (accept) begin
            if (is_mark) begin
                // mark closes the frame and opens the next one as bit 0
                frame_next = '0;
                pos_next   = dcf_pkg::POS_W'(1);
                bad_next   = 1'b0;
            end
            else begin
                if (is_one && (pos_reg < POS_END)) begin
                    frame_next = frame_reg | bit_mask;
                end
                if (!is_zero && !is_one) begin
                    bad_next = 1'b1;
                end
                if (pos_reg != POS_SAT) begin
                    pos_next = pos_reg + dcf_pkg::POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            zero_min_reg <= dcf_pkg::ZERO_MIN_RST;
            zero_max_reg <= dcf_pkg::ZERO_MAX_RST;
            one_min_reg  <= dcf_pkg::ONE_MIN_RST;
            one_max_reg  <= dcf_pkg::ONE_MAX_RST;
            gap_min_reg  <= dcf_pkg::GAP_MIN_RST;
            gap_max_reg  <= dcf_pkg::GAP_MAX_RST;
            frame_reg    <= '0;
            pos_reg      <= '0;
            bad_reg      <= 1'b1;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dcf_pkg::REG_ZERO_MIN: zero_min_reg <= cfg_data;
                    dcf_pkg::REG_ZERO_MAX: zero_max_reg <= cfg_data;
                    dcf_pkg::REG_ONE_MIN:  one_min_reg  <= cfg_data;
                    dcf_pkg::REG_ONE_MAX:  one_max_reg  <= cfg_data;
                    dcf_pkg::REG_GAP_MIN:  gap_min_reg  <= cfg_data;
                    dcf_pkg::REG_GAP_MAX:  gap_max_reg  <= cfg_data;
                    default: ;
                endcase
            end
            frame_reg <= frame_next;
            pos_reg   <= pos_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

/* hw/rtl/dcf_queue.sv */
// short queue of closed frames between front end and decoder
module dcf_queue #(
    parameter int unsigned WIDTH = 60
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [WIDTH-1:0]  push_data,
    input  logic              pop,
    output logic [WIDTH-1:0]  head,
    output dcf_pkg::q_stat_t  q_stat
);

    localparam int unsigned PTR_W = (dcf_pkg::Q_DEPTH > 1) ? $clog2(dcf_pkg::Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(dcf_pkg::Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(dcf_pkg::Q_DEPTH - 1);

    logic [WIDTH-1:0] mem [dcf_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign q_stat.full  = (cnt_reg == CNT_W'(dcf_pkg::Q_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* hw/rtl/dcf_back.sv */
// back end: frame checks, bcd decode and registered result word
module dcf_back #(
    parameter int unsigned FRAME_BITS = 59
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [FRAME_BITS:0]  head,
    input  dcf_pkg::q_stat_t     q_stat,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           status,
    output logic [6:0]           minutes,
    output logic [5:0]           hours,
    output logic                 is_pm,
    output logic [5:0]           day,
    output logic [2:0]           weekday,
    output logic [4:0]           month,
    output logic [7:0]           year
);

    logic [FRAME_BITS-1:0] fb;
    logic                  frame_bad;
    logic                  load;
    dcf_pkg::status_t      st;
    logic [7:0]            hr_full;
    logic [7:0]            min_d, day_d, mon_d, yr_d;

    logic       out_valid_reg;
    logic [2:0] status_reg;
    logic [6:0] minutes_reg;
    logic [5:0] hours_reg;
    logic       is_pm_reg;
    logic [5:0] day_reg;
    logic [2:0] weekday_reg;
    logic [4:0] month_reg;
    logic [7:0] year_reg;

    assign fb        = head[FRAME_BITS:1];
    assign frame_bad = head[0];
    assign load      = !out_valid_reg || out_ready;
    assign pop       = load && !q_stat.empty;

    assign hr_full = dcf_pkg::bcd8({2'b00, fb[34:29]});
    assign min_d   = dcf_pkg::bcd8({1'b0, fb[27:21]});
    assign day_d   = dcf_pkg::bcd8({2'b00, fb[41:36]});
    assign mon_d   = dcf_pkg::bcd8({3'b000, fb[49:45]});
    assign yr_d    = dcf_pkg::bcd8(fb[57:50]);

    always_comb
    begin
        if (frame_bad) begin
            st = dcf_pkg::ST_BAD_FRAME;
        end
        else if (fb[0]) begin
            st = dcf_pkg::ST_START_BIT;
        end
        else if (!fb[20]) begin
            st = dcf_pkg::ST_TIME_BIT;
        end
        else if (^fb[28:21]) begin
            st = dcf_pkg::ST_MIN_PARITY;
        end
        else if (^fb[35:29]) begin
            st = dcf_pkg::ST_HR_PARITY;
        end
        else if (^fb[58:36]) begin
            st = dcf_pkg::ST_DATE_PAR;
        end
        else begin
            st = dcf_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (load) begin
            out_valid_reg <= !q_stat.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            status_reg <= st;
            if (st == dcf_pkg::ST_OK) begin
                minutes_reg <= min_d[6:0];
                if (hr_full > {2'b00, dcf_pkg::PM_HOUR}) begin
                    hours_reg <= hr_full[5:0] - dcf_pkg::PM_HOUR;
                    is_pm_reg <= 1'b1;
                end
                else begin
                    hours_reg <= hr_full[5:0];
                    is_pm_reg <= 1'b0;
                end
                day_reg     <= day_d[5:0];
                weekday_reg <= fb[44:42];
                month_reg   <= mon_d[4:0];
                year_reg    <= yr_d;
            end
            else begin
                minutes_reg <= '0;
                hours_reg   <= '0;
                is_pm_reg   <= 1'b0;
                day_reg     <= '0;
                weekday_reg <= '0;
                month_reg   <= '0;
                year_reg    <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign minutes   = minutes_reg;
    assign hours     = hours_reg;
    assign is_pm     = is_pm_reg;
    assign day       = day_reg;
    assign weekday   = weekday_reg;
    assign month     = month_reg;
    assign year      = year_reg;

endmodule

/* verif/minute_sb_pkg.sv */
// frame decoder model and result scoreboard for the dcf77 minute frame receiver testbench
package minute_sb_pkg;

    localparam int FRAME_LEN = 59;

    typedef struct packed {
        dcf_pkg::status_t status;
        logic [6:0]       minutes;
        logic [5:0]       hours;
        logic             is_pm;
        logic [5:0]       day;
        logic [2:0]       weekday;
        logic [4:0]       month;
        logic [7:0]       year;
    } minute_word_t;

    class minute_scoreboard;

        // threshold copy, exclusive bounds
        logic [11:0] zero_lo, zero_hi, one_lo, one_hi, gap_lo, gap_hi;

        // running frame
        logic [58:0] frame_bits;
        logic [5:0]  bit_pos;
        bit          frame_bad;

        minute_word_t pending_words[$];
        int unsigned  pulses_noted, writes_noted, words_checked, words_ok, errors;

        function new();
            zero_lo = dcf_pkg::ZERO_MIN_RST;
            zero_hi = dcf_pkg::ZERO_MAX_RST;
            one_lo  = dcf_pkg::ONE_MIN_RST;
            one_hi  = dcf_pkg::ONE_MAX_RST;
            gap_lo  = dcf_pkg::GAP_MIN_RST;
            gap_hi  = dcf_pkg::GAP_MAX_RST;
            frame_bits = '0;
            bit_pos    = '0;
            frame_bad  = 1'b1;
        endfunction

        function bit in_win(logic [11:0] v, logic [11:0] lo, logic [11:0] hi);
            return (v > lo) && (v < hi);
        endfunction

        function void note_config(logic [2:0] idx, logic [11:0] val);
            writes_noted++;
            case (idx)
                dcf_pkg::REG_ZERO_MIN: zero_lo = val;
                dcf_pkg::REG_ZERO_MAX: zero_hi = val;
                dcf_pkg::REG_ONE_MIN:  one_lo  = val;
                dcf_pkg::REG_ONE_MAX:  one_hi  = val;
                dcf_pkg::REG_GAP_MIN:  gap_lo  = val;
                dcf_pkg::REG_GAP_MAX:  gap_hi  = val;
                default: ;
            endcase
        endfunction

        // low digit taken as binary, no clamp above nine
        function int unsigned loose_bcd(logic [7:0] v);
            return v[3:0] + (v[4] ? 10 : 0) + (v[5] ? 20 : 0) + (v[6] ? 40 : 0)
                 + (v[7] ? 80 : 0);
        endfunction

        function void note_pulse(logic [11:0] pw, logic [11:0] pl);
            bit           is_zero;
            bit           is_one;
            minute_word_t w;
            int unsigned  hr;
            pulses_noted++;
            is_zero = in_win(pw, zero_lo, zero_hi);
            is_one  = !is_zero && in_win(pw, one_lo, one_hi);
            if (is_zero && in_win(pl, gap_lo, gap_hi)) begin
                w = '0;
                if (frame_bad || int'(bit_pos) != FRAME_LEN)
                    w.status = dcf_pkg::ST_BAD_FRAME;
                else if (frame_bits[0])
                    w.status = dcf_pkg::ST_START_BIT;
                else if (!frame_bits[20])
                    w.status = dcf_pkg::ST_TIME_BIT;
                else if (^frame_bits[28:21])
                    w.status = dcf_pkg::ST_MIN_PARITY;
                else if (^frame_bits[35:29])
                    w.status = dcf_pkg::ST_HR_PARITY;
                else if (^frame_bits[58:36])
                    w.status = dcf_pkg::ST_DATE_PAR;
                else begin
                    w.status  = dcf_pkg::ST_OK;
                    w.minutes = 7'(loose_bcd({1'b0, frame_bits[27:21]}));
                    hr = loose_bcd({2'b0, frame_bits[34:29]});
                    if (hr > 12) begin
                        w.hours = 6'(hr - 12);
                        w.is_pm = 1'b1;
                    end
                    else
                        w.hours = 6'(hr);
                    w.day     = 6'(loose_bcd({2'b0, frame_bits[41:36]}));
                    w.weekday = frame_bits[44:42];
                    w.month   = 5'(loose_bcd({3'b0, frame_bits[49:45]}));
                    w.year    = 8'(loose_bcd(frame_bits[57:50]));
                end
                pending_words.push_back(w);
                // the minute mark itself is bit 0 of the next frame
                frame_bits = '0;
                bit_pos    = 6'd1;
                frame_bad  = 1'b0;
                return;
            end
            if (is_one && int'(bit_pos) < FRAME_LEN)
                frame_bits[bit_pos] = 1'b1;
            if (!is_zero && !is_one)
                frame_bad = 1'b1;
            if (bit_pos != 6'd63)
                bit_pos = bit_pos + 6'd1;
        endfunction

        function int unsigned outstanding();
            return pending_words.size();
        endfunction

        function void report(string what, logic [7:0] want_v, logic [7:0] got_v);
            errors++;
            $display("%0t mismatch on %s: expected %0d actual %0d",
                     $time, what, want_v, got_v);
        endfunction

        function void check_result(minute_word_t got);
            minute_word_t want;
            words_checked++;
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t minute word with nothing pending: %s %0d",
                         $time, "expected none actual status", got.status);
                return;
            end
            want = pending_words.pop_front();
            if (want.status == dcf_pkg::ST_OK)
                words_ok++;
            if (got.status  !== want.status)  report("status",  want.status,  got.status);
            if (got.minutes !== want.minutes) report("minutes", want.minutes, got.minutes);
            if (got.hours   !== want.hours)   report("hours",   want.hours,   got.hours);
            if (got.is_pm   !== want.is_pm)   report("is_pm",   want.is_pm,   got.is_pm);
            if (got.day     !== want.day)     report("day",     want.day,     got.day);
            if (got.weekday !== want.weekday) report("weekday", want.weekday, got.weekday);
            if (got.month   !== want.month)   report("month",   want.month,   got.month);
            if (got.year    !== want.year)    report("year",    want.year,    got.year);
        endfunction

        function void leftover_check();
            if (pending_words.size() != 0) begin
                errors++;
                $display("%0t minute words never delivered: expected %0d actual 0",
                         $time, pending_words.size());
            end
        endfunction

    endclass

endpackage

/* verif/tb.sv */
// testbench for the dcf77 minute frame receiver: random pulse trains against a frame model
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // out-of-range register indexes, writes there must be dropped
    localparam logic [2:0] IDX_SPARE_A = 3'd6;
    localparam logic [2:0] IDX_SPARE_B = 3'd7;

    localparam int SENDER_IDLE_PCT = 63;
    localparam int BOTH_IDLE_PCT   = 35;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 600000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {
        SET_RESET_VALUES, SET_WIDE, SET_NARROW, SET_HIGH, SET_DEAD, SET_RANDOM
    } threshold_set_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [11:0] pulse_width = '0;
    logic [11:0] period_length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [6:0]  minutes;
    logic [5:0]  hours;
    logic        is_pm;
    logic [5:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  month;
    logic [7:0]  year;

    minute_sb_pkg::minute_scoreboard sb;
    minute_sb_pkg::minute_word_t     seen_word;
    int unsigned      in_idle_pct = 0;
    int unsigned      out_stall_pct = 0;
    int unsigned      cycle_count = 0;
    int unsigned      phases_run = 0;

    dcf77_frame_receiver DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pulse_width   (pulse_width),
        .period_length (period_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .minutes       (minutes),
        .hours         (hours),
        .is_pm         (is_pm),
        .day           (day),
        .weekday       (weekday),
        .month         (month),
        .year          (year)
    );

    always #1 clk = ~clk;

    // hard stop in case the block hangs on a handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // result side: check every accepted word, then pick ready for the next edge
    // all inputs change by nonblocking writes, so values read here are pre-edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_word.status  = dcf_pkg::status_t'(status);
            seen_word.minutes = minutes;
            seen_word.hours   = hours;
            seen_word.is_pm   = is_pm;
            seen_word.day     = day;
            seen_word.weekday = weekday;
            seen_word.month   = month;
            seen_word.year    = year;
            sb.check_result(seen_word);
        end
        out_ready <= ($urandom_range(99, 0) >= out_stall_pct);
    end

    function automatic logic [11:0] rand12(int unsigned lo, int unsigned hi);
        int unsigned v;
        v = $urandom_range(hi, lo);
        return v[11:0];
    endfunction

    // value strictly inside (lo, hi), biased toward the edges; lo when empty
    function automatic logic [11:0] pick_inside(logic [11:0] lo, logic [11:0] hi);
        int unsigned l;
        int unsigned h;
        l = lo;
        h = hi;
        if (h < l + 2)
            return lo;
        case ($urandom_range(3, 0))
            0: return 12'(l + 1);
            1: return 12'(h - 1);
            default: return rand12(l + 1, h - 1);
        endcase
    endfunction

    // value outside the window; the lower bound itself is always outside
    function automatic logic [11:0] pick_outside(logic [11:0] lo, logic [11:0] hi);
        logic [11:0] v;
        for (int n = 0; n < 32; n++)
        begin
            case ($urandom_range(3, 0))
                0: v = lo;
                1: v = hi;
                default: v = rand12(0, 4095);
            endcase
            if (!sb.in_win(v, lo, hi))
                return v;
        end
        return lo;
    endfunction

    // one-bit width that is not also a zero-bit width when the windows overlap
    function automatic logic [11:0] pick_one_width();
        logic [11:0] v;
        v = pick_inside(sb.one_lo, sb.one_hi);
        for (int n = 0; n < 32 && sb.in_win(v, sb.zero_lo, sb.zero_hi); n++)
            v = pick_inside(sb.one_lo, sb.one_hi);
        return v;
    endfunction

    // width in neither window, thresholds themselves preferred
    function automatic logic [11:0] pick_unknown_width();
        logic [11:0] v;
        for (int n = 0; n < 32; n++)
        begin
            case ($urandom_range(5, 0))
                0: v = sb.zero_lo;
                1: v = sb.zero_hi;
                2: v = sb.one_lo;
                3: v = sb.one_hi;
                default: v = rand12(0, 4095);
            endcase
            if (!sb.in_win(v, sb.zero_lo, sb.zero_hi) && !sb.in_win(v, sb.one_lo, sb.one_hi))
                return v;
        end
        return 12'd0;
    endfunction

    function automatic logic [11:0] noise_value();
        case ($urandom_range(7, 0))
            0: return 12'd0;
            1: return 12'hFFF;
            2: return sb.zero_hi + 12'(int'($urandom_range(2, 0)) - 1);
            3: return sb.gap_lo + 12'(int'($urandom_range(2, 0)) - 1);
            default: return rand12(0, 4095);
        endcase
    endfunction

    function automatic logic [7:0] to_bcd(int unsigned v);
        logic [3:0] tens;
        logic [3:0] units;
        tens  = 4'(v / 10);
        units = 4'(v % 10);
        return {tens, units};
    endfunction

    // frame with start bits and even parities right; raw puts arbitrary bits in the fields
    function automatic logic [58:0] make_frame(bit raw);
        logic [58:0] f;
        logic [31:0] r0;
        logic [31:0] r1;
        logic [7:0]  b;
        f  = '0;
        r0 = $urandom;
        r1 = $urandom;
        f[19:1] = r0[18:0];
        f[20]   = 1'b1;
        if (raw)
        begin
            f[27:21] = r0[25:19];
            f[34:29] = r1[5:0];
            f[57:36] = r1[27:6];
        end
        else
        begin
            b = to_bcd($urandom_range(59, 0));
            f[27:21] = b[6:0];
            b = to_bcd($urandom_range(23, 0));
            f[34:29] = b[5:0];
            b = to_bcd($urandom_range(31, 1));
            f[41:36] = b[5:0];
            b = to_bcd($urandom_range(7, 1));
            f[44:42] = b[2:0];
            b = to_bcd($urandom_range(12, 1));
            f[49:45] = b[4:0];
            f[57:50] = to_bcd($urandom_range(99, 0));
        end
        f[28] = ^f[27:21];
        f[35] = ^f[34:29];
        f[58] = ^f[57:36];
        return f;
    endfunction

    // one pulse word; valid stays up until the edge that takes it
    task automatic send_pulse(input logic [11:0] pw, input logic [11:0] pl);
        while ($urandom_range(99, 0) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        pulse_width   <= pw;
        period_length <= pl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_pulse(pw, pl);
    endtask

    task automatic send_bit(input bit one);
        if (one)
        begin
            // gap does not matter for a one, so the minute window is used too
            if ($urandom_range(2, 0) == 0)
                send_pulse(pick_one_width(), pick_inside(sb.gap_lo, sb.gap_hi));
            else
                send_pulse(pick_one_width(), rand12(0, 4095));
        end
        else
            send_pulse(pick_inside(sb.zero_lo, sb.zero_hi), pick_outside(sb.gap_lo, sb.gap_hi));
    endtask

    task automatic send_minute_mark();
        send_pulse(pick_inside(sb.zero_lo, sb.zero_hi), pick_inside(sb.gap_lo, sb.gap_hi));
    endtask

    // bits 1 .. nbits-1 then the closing minute mark; bits past the frame are random
    task automatic send_frame(input logic [58:0] f, input int nbits, input int unknown_at);
        for (int i = 1; i < nbits; i++)
        begin
            if (i == unknown_at)
                send_pulse(pick_unknown_width(), rand12(0, 4095));
            else if (i < minute_sb_pkg::FRAME_LEN)
                send_bit(f[i]);
            else
                send_bit($urandom_range(1, 0));
        end
        send_minute_mark();
    endtask

    // sender holds off until every pending minute word is out and the block is quiet
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // caller lowers cfg_valid after the last write of a batch
    task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.note_config(idx, val);
    endtask

    task automatic program_thresholds(input logic [11:0] z_lo, input logic [11:0] z_hi,
                                      input logic [11:0] o_lo, input logic [11:0] o_hi,
                                      input logic [11:0] g_lo, input logic [11:0] g_hi);
        write_reg(IDX_SPARE_A, 12'd0);
        write_reg(dcf_pkg::REG_ZERO_MIN, z_lo);
        write_reg(dcf_pkg::REG_ZERO_MAX, z_hi);
        write_reg(dcf_pkg::REG_ONE_MIN, o_lo);
        write_reg(dcf_pkg::REG_ONE_MAX, o_hi);
        write_reg(dcf_pkg::REG_GAP_MIN, g_lo);
        write_reg(dcf_pkg::REG_GAP_MAX, g_hi);
        write_reg(IDX_SPARE_B, 12'hFFF);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_thresholds(input threshold_set_t which);
        logic [11:0] lo [3];
        logic [11:0] hi [3];
        // random windows are never empty so minute marks stay reachable
        for (int k = 0; k < 3; k++)
        begin
            lo[k] = rand12(0, 4093);
            hi[k] = rand12(int'(lo[k]) + 2, 4095);
        end
        case (which)
            SET_RESET_VALUES:
                program_thresholds(dcf_pkg::ZERO_MIN_RST, dcf_pkg::ZERO_MAX_RST,
                                   dcf_pkg::ONE_MIN_RST, dcf_pkg::ONE_MAX_RST,
                                   dcf_pkg::GAP_MIN_RST, dcf_pkg::GAP_MAX_RST);
            // windows at the range ends, adjoining zero and one windows
            SET_WIDE:
                program_thresholds(12'd0, 12'd1000, 12'd999, 12'hFFF, 12'd0, 12'hFFF);
            // single-value windows
            SET_NARROW:
                program_thresholds(12'd99, 12'd101, 12'd199, 12'd201, 12'd1999, 12'd2001);
            SET_HIGH:
                program_thresholds(12'd3000, 12'hFFF, 12'd0, 12'd3001, 12'd4093, 12'hFFF);
            // no zero width and no minute gap can exist: no words at all
            SET_DEAD:
                program_thresholds(12'hFFF, 12'd0, 12'd10, 12'd20, 12'd500, 12'd500);
            default:
                program_thresholds(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
        endcase
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin in_idle_pct = SENDER_IDLE_PCT; out_stall_pct = 0; end
            IDLE_RECEIVER: begin in_idle_pct = 0; out_stall_pct = SENDER_IDLE_PCT; end
            IDLE_BOTH:     begin in_idle_pct = BOTH_IDLE_PCT; out_stall_pct = BOTH_IDLE_PCT; end
            default:       begin in_idle_pct = 0; out_stall_pct = 0; end
        endcase
    endtask

    // boundaries of the reset windows, the first minute mark and short frames
    task automatic run_directed();
        send_pulse(12'd0, 12'd0);
        send_pulse(12'hFFF, 12'hFFF);
        send_pulse(dcf_pkg::ZERO_MIN_RST, dcf_pkg::GAP_MIN_RST + 12'd1);
        send_pulse(dcf_pkg::ZERO_MAX_RST, dcf_pkg::GAP_MIN_RST + 12'd1);
        send_pulse(dcf_pkg::ONE_MIN_RST, 12'd1000);
        send_pulse(dcf_pkg::ONE_MAX_RST, 12'd1000);
        send_pulse(dcf_pkg::ZERO_MIN_RST + 12'd1, dcf_pkg::GAP_MIN_RST);
        send_pulse(dcf_pkg::ZERO_MAX_RST - 12'd1, dcf_pkg::GAP_MAX_RST);
        // one-width pulse with a minute gap is only a one bit
        send_pulse(dcf_pkg::ONE_MAX_RST - 12'd1, 12'd1800);
        // first minute mark still sees the bad frame from reset
        send_pulse(12'd100, dcf_pkg::GAP_MIN_RST + 12'd1);
        send_pulse(12'd41, dcf_pkg::GAP_MAX_RST - 12'd1);
        send_pulse(dcf_pkg::ONE_MIN_RST + 12'd1, 12'd1000);
        send_pulse(12'd129, 12'd1000);
        send_pulse(12'd60, 12'd2000);
        send_pulse(12'hAAA, 12'h555);
        send_pulse(12'h555, 12'hAAA);
        send_pulse(12'd80, 12'd1700);
    endtask

    task automatic run_phase(input threshold_set_t which, input idle_mode_t mode,
                             input int unsigned pulse_budget, input int unsigned word_goal);
        int unsigned pulses_at;
        int unsigned words_at;
        int unsigned kind;
        logic [58:0] f;
        wait_drained();
        apply_thresholds(which);
        set_idle(mode);
        phases_run++;
        pulses_at = sb.pulses_noted;
        words_at  = sb.words_checked + sb.outstanding();
        while (sb.pulses_noted - pulses_at < pulse_budget ||
               sb.words_checked + sb.outstanding() - words_at < word_goal)
        begin
            if ($urandom_range(9, 0) == 0)
                wait_drained();
            kind = $urandom_range(99, 0);
            f = make_frame(kind >= 55 && kind < 65);
            if (kind < 65)
                send_frame(f, minute_sb_pkg::FRAME_LEN, 0);
            else if (kind < 73)
            begin
                // single flipped bit: time bit or parity failure, or just other data
                f[$urandom_range(58, 1)] ^= 1'b1;
                send_frame(f, minute_sb_pkg::FRAME_LEN, 0);
            end
            else if (kind < 79)
                send_frame(f, $urandom_range(58, 1), 0);
            else if (kind < 84)
                send_frame(f, $urandom_range(70, 60), 0);
            else if (kind < 90)
                send_frame(f, minute_sb_pkg::FRAME_LEN, $urandom_range(58, 1));
            else if (kind < 96)
                repeat ($urandom_range(8, 1)) send_pulse(noise_value(), noise_value());
            else
                // back-to-back minute marks fill the word queue under a stalled receiver
                repeat ($urandom_range(5, 2)) send_minute_mark();
        end
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(IDLE_NONE);
        run_directed();

        run_phase(SET_RESET_VALUES, IDLE_SENDER,   130, 2);
        run_phase(SET_WIDE,         IDLE_RECEIVER, 130, 2);
        run_phase(SET_NARROW,       IDLE_BOTH,     130, 2);
        run_phase(SET_HIGH,         IDLE_NONE,     130, 2);
        run_phase(SET_DEAD,         IDLE_BOTH,     40,  0);
        run_phase(SET_RANDOM,       IDLE_RECEIVER, 130, 2);
        run_phase(SET_RANDOM,       IDLE_SENDER,   130, 2);
        run_phase(SET_RESET_VALUES, IDLE_NONE,     130, 2);

        wait_drained();
        repeat (20) @(posedge clk);
        sb.leftover_check();

        $display("run: %0d pulses over %0d threshold settings, %0d register writes",
                 sb.pulses_noted, phases_run, sb.writes_noted);
        $display("run: %0d minute words compared, %0d fully decoded, %0d errors",
                 sb.words_checked, sb.words_ok, sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* dcf77_frame_receiver.f */
hw/rtl/dcf_pkg.sv
hw/rtl/dcf_front.sv
hw/rtl/dcf_queue.sv
hw/rtl/dcf_back.sv
hw/rtl/dcf77_frame_receiver.sv
verif/minute_sb_pkg.sv
verif/tb.sv
